// ===== hw/rtl/assert_macros.svh =====
// assertion macros used by ft_sensor_gravity_compensation.sv
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked at every rising edge outside reset
`define ASSERT_AT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// condition that must never be seen outside reset
`define ASSERT_NEVER(label, clk, rst_n, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

// ===== hw/rtl/ftgc_pkg.sv =====
// types and constants of the force/torque gravity compensation block
// no dependencies
package ftgc_pkg;

  localparam int ROT_W       = 16;
  localparam int MAG_W       = ROT_W + 1;
  localparam int IDX_W       = 6;
  localparam int STORE_DEPTH = 42;
  localparam int NUM_CH      = 6;
  localparam int NUM_AXIS    = 3;

  localparam int SLOT_POS_F  = 6;
  localparam int SLOT_NEG_F  = 15;
  localparam int SLOT_POS_T  = 24;
  localparam int SLOT_NEG_T  = 33;

  typedef enum logic {
    FUNC_WRITE  = 1'b0,
    FUNC_SAMPLE = 1'b1
  } func_t;

  typedef struct packed {
    logic             en;
    logic [IDX_W-1:0] idx;
  } store_wr_t;

endpackage

// ===== hw/rtl/ftgc_store.sv =====
// calibration store: bias words and signed load tables, cleared at reset
// selects the table row per axis from the projection sign; uses ftgc_pkg
module ftgc_store #(
  parameter int SAMPLE_WIDTH = 24
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  ftgc_pkg::store_wr_t                    wr,
  input  logic signed [SAMPLE_WIDTH-1:0]         wr_value,
  input  logic [ftgc_pkg::NUM_AXIS-1:0]          pos,
  output logic signed [SAMPLE_WIDTH-1:0]         bias [ftgc_pkg::NUM_CH],
  output logic signed [SAMPLE_WIDTH-1:0]         coef [ftgc_pkg::NUM_CH][ftgc_pkg::NUM_AXIS]
);

  logic signed [SAMPLE_WIDTH-1:0] store_r [ftgc_pkg::STORE_DEPTH];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < ftgc_pkg::STORE_DEPTH; i++) begin
        store_r[i] <= '0;
      end
    end else if (wr.en && (wr.idx < ftgc_pkg::IDX_W'(ftgc_pkg::STORE_DEPTH))) begin
      store_r[wr.idx] <= wr_value;
    end
  end

  for (genvar ch = 0; ch < ftgc_pkg::NUM_CH; ch++) begin : g_ch
    localparam int C      = ch % 3;
    localparam int BASE_P = (ch < 3) ? ftgc_pkg::SLOT_POS_F : ftgc_pkg::SLOT_POS_T;
    localparam int BASE_N = (ch < 3) ? ftgc_pkg::SLOT_NEG_F : ftgc_pkg::SLOT_NEG_T;

    assign bias[ch] = store_r[ch];

    for (genvar a = 0; a < ftgc_pkg::NUM_AXIS; a++) begin : g_axis
      localparam int IDX_P = BASE_P + 3 * a + C;
      localparam int IDX_N = BASE_N + 3 * a + C;
      assign coef[ch][a] = pos[a] ? store_r[IDX_P] : store_r[IDX_N];
    end
  end

endmodule

// ===== hw/rtl/ftgc_lane.sv =====
// one load lane: coefficient times projection magnitude, registered,
// then floor shift by the rotation fraction bits; uses ftgc_pkg
module ftgc_lane #(
  parameter int SAMPLE_WIDTH  = 24,
  parameter int ROT_FRAC_BITS = 14,
  parameter int PROD_W        = 42,
  parameter int TERM_W        = 28
) (
  input  logic                              clk,
  input  logic                              en,
  input  logic signed [SAMPLE_WIDTH-1:0]    coef,
  input  logic [ftgc_pkg::MAG_W-1:0]        mag,
  output logic signed [TERM_W-1:0]          term
);

  logic signed [ftgc_pkg::MAG_W:0] mag_s;
  logic signed [PROD_W-1:0]        prod_nxt;
  logic signed [PROD_W-1:0]        prod_r;
  logic signed [PROD_W-1:0]        shifted;

  assign mag_s    = $signed({1'b0, mag});
  assign prod_nxt = coef * mag_s;

  always_ff @(posedge clk) begin
    if (en) begin
      prod_r <= prod_nxt;
    end
  end

  // arithmetic shift gives floor rounding
  assign shifted = prod_r >>> ROT_FRAC_BITS;
  assign term    = shifted[TERM_W-1:0];

endmodule

// ===== hw/rtl/ftgc_merge.sv =====
// merge stage of one channel: bias-removed reading minus the three axis
// loads, saturated into the output register; uses ftgc_pkg
module ftgc_merge #(
  parameter int SAMPLE_WIDTH = 24,
  parameter int TERM_W       = 28,
  parameter int ACC_W        = 44
) (
  input  logic                            clk,
  input  logic                            en,
  input  logic signed [SAMPLE_WIDTH:0]    diff,
  input  logic signed [TERM_W-1:0]        term [ftgc_pkg::NUM_AXIS],
  output logic signed [SAMPLE_WIDTH-1:0]  comp
);

  localparam logic signed [ACC_W-1:0] SAT_MAX =
    {{(ACC_W-SAMPLE_WIDTH+1){1'b0}}, {(SAMPLE_WIDTH-1){1'b1}}};
  localparam logic signed [ACC_W-1:0] SAT_MIN =
    {{(ACC_W-SAMPLE_WIDTH+1){1'b1}}, {(SAMPLE_WIDTH-1){1'b0}}};

  logic signed [ACC_W-1:0]        acc;
  logic signed [SAMPLE_WIDTH-1:0] comp_nxt;
  logic signed [SAMPLE_WIDTH-1:0] comp_r;

  always_comb begin
    acc = ACC_W'(diff) - ACC_W'(term[0]) - ACC_W'(term[1]) - ACC_W'(term[2]);
    if (acc > SAT_MAX) begin
      comp_nxt = SAT_MAX[SAMPLE_WIDTH-1:0];
    end else if (acc < SAT_MIN) begin
      comp_nxt = SAT_MIN[SAMPLE_WIDTH-1:0];
    end else begin
      comp_nxt = acc[SAMPLE_WIDTH-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      comp_r <= comp_nxt;
    end
  end

  assign comp = comp_r;

endmodule

// ===== hw/rtl/ft_sensor_gravity_compensation.sv =====
// a sample request's result passes the stage 1 registers, the lane product registers and the output register
// throughput: one request per cycle while out_stall is low, 18 multiplier lanes in parallel
// a stage only stalls when every later stage holds a waiting result
// calibration write requests give no result and take effect for the next sample
// synchronous active-low reset clears the 42-word calibration store and all valids
// uses ftgc_pkg, ftgc_store, ftgc_lane, ftgc_merge and assert_macros.svh
`include "assert_macros.svh"

module ft_sensor_gravity_compensation #(
  parameter int SAMPLE_WIDTH  = 24,
  parameter int ROT_FRAC_BITS = 14
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  logic                                  in_func,
  input  logic [ftgc_pkg::IDX_W-1:0]            in_coef_index,
  input  logic signed [SAMPLE_WIDTH-1:0]        in_coef_value,
  input  logic signed [ftgc_pkg::ROT_W-1:0]     in_rot_zx,
  input  logic signed [ftgc_pkg::ROT_W-1:0]     in_rot_zy,
  input  logic signed [ftgc_pkg::ROT_W-1:0]     in_rot_zz,
  input  logic signed [SAMPLE_WIDTH-1:0]        in_raw_fx,
  input  logic signed [SAMPLE_WIDTH-1:0]        in_raw_fy,
  input  logic signed [SAMPLE_WIDTH-1:0]        in_raw_fz,
  input  logic signed [SAMPLE_WIDTH-1:0]        in_raw_tx,
  input  logic signed [SAMPLE_WIDTH-1:0]        in_raw_ty,
  input  logic signed [SAMPLE_WIDTH-1:0]        in_raw_tz,
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output logic signed [SAMPLE_WIDTH-1:0]        out_comp_fx,
  output logic signed [SAMPLE_WIDTH-1:0]        out_comp_fy,
  output logic signed [SAMPLE_WIDTH-1:0]        out_comp_fz,
  output logic signed [SAMPLE_WIDTH-1:0]        out_comp_tx,
  output logic signed [SAMPLE_WIDTH-1:0]        out_comp_ty,
  output logic signed [SAMPLE_WIDTH-1:0]        out_comp_tz
);

  localparam int NCH    = ftgc_pkg::NUM_CH;
  localparam int NAX    = ftgc_pkg::NUM_AXIS;
  localparam int MAG_W  = ftgc_pkg::MAG_W;
  localparam int PROD_W = SAMPLE_WIDTH + ftgc_pkg::ROT_W + 2;
  localparam int TERM_W = PROD_W - ROT_FRAC_BITS;
  localparam int ACC_W  = SAMPLE_WIDTH + ftgc_pkg::ROT_W + 4;

  logic en1, en2, en3;
  logic acc_any, acc_sample, acc_write;
  logic v1_r, v1_nxt, v2_r, v2_nxt, out_valid_r, out_valid_nxt;

  ftgc_pkg::store_wr_t            wr;
  logic signed [ftgc_pkg::ROT_W-1:0] rot [NAX];
  logic signed [SAMPLE_WIDTH-1:0] raw [NCH];
  logic signed [SAMPLE_WIDTH-1:0] bias [NCH];
  logic signed [SAMPLE_WIDTH-1:0] coef [NCH][NAX];
  logic signed [SAMPLE_WIDTH-1:0] comp [NCH];
  logic [NAX-1:0]                 pos;
  logic [MAG_W-1:0]               mag_nxt [NAX];
  logic [MAG_W-1:0]               mag_r [NAX];
  logic signed [SAMPLE_WIDTH-1:0] coef_r [NCH][NAX];
  logic signed [SAMPLE_WIDTH:0]   diff_nxt [NCH];
  logic signed [SAMPLE_WIDTH:0]   diff1_r [NCH];
  logic signed [SAMPLE_WIDTH:0]   diff2_r [NCH];
  logic signed [TERM_W-1:0]       term [NCH][NAX];

  // pipeline control: a stage moves when the next one is empty or moving
  assign en3      = !out_valid_r || !out_stall;
  assign en2      = !v2_r || en3;
  assign en1      = !v1_r || en2;
  assign in_stall = !en1;

  assign acc_any    = in_valid && en1;
  assign acc_sample = acc_any && (in_func == ftgc_pkg::FUNC_SAMPLE);
  assign acc_write  = acc_any && (in_func == ftgc_pkg::FUNC_WRITE);

  assign v1_nxt        = en1 ? acc_sample : v1_r;
  assign v2_nxt        = en2 ? v1_r : v2_r;
  assign out_valid_nxt = en3 ? v2_r : out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      v1_r        <= v1_nxt;
      v2_r        <= v2_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign wr.en  = acc_write;
  assign wr.idx = in_coef_index;

  assign rot[0] = in_rot_zx;
  assign rot[1] = in_rot_zy;
  assign rot[2] = in_rot_zz;
  assign raw[0] = in_raw_fx;
  assign raw[1] = in_raw_fy;
  assign raw[2] = in_raw_fz;
  assign raw[3] = in_raw_tx;
  assign raw[4] = in_raw_ty;
  assign raw[5] = in_raw_tz;

  // gravity projection is minus the rotation entry
  always_comb begin
    for (int a = 0; a < NAX; a++) begin
      pos[a]     = rot[a][ftgc_pkg::ROT_W-1];
      mag_nxt[a] = pos[a] ? MAG_W'(-$signed({rot[a][ftgc_pkg::ROT_W-1], rot[a]}))
                          : MAG_W'($signed({rot[a][ftgc_pkg::ROT_W-1], rot[a]}));
    end
    for (int c = 0; c < NCH; c++) begin
      diff_nxt[c] = (SAMPLE_WIDTH+1)'(raw[c]) - (SAMPLE_WIDTH+1)'(bias[c]);
    end
  end

  ftgc_store #(
    .SAMPLE_WIDTH(SAMPLE_WIDTH)
  ) u_store (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr       (wr),
    .wr_value (in_coef_value),
    .pos      (pos),
    .bias     (bias),
    .coef     (coef)
  );

  always_ff @(posedge clk) begin
    if (en1) begin
      mag_r   <= mag_nxt;
      coef_r  <= coef;
      diff1_r <= diff_nxt;
    end
    if (en2) begin
      diff2_r <= diff1_r;
    end
  end

  for (genvar c = 0; c < NCH; c++) begin : g_ch
    for (genvar a = 0; a < NAX; a++) begin : g_lane
      ftgc_lane #(
        .SAMPLE_WIDTH  (SAMPLE_WIDTH),
        .ROT_FRAC_BITS (ROT_FRAC_BITS),
        .PROD_W        (PROD_W),
        .TERM_W        (TERM_W)
      ) u_lane (
        .clk  (clk),
        .en   (en2),
        .coef (coef_r[c][a]),
        .mag  (mag_r[a]),
        .term (term[c][a])
      );
    end

    ftgc_merge #(
      .SAMPLE_WIDTH (SAMPLE_WIDTH),
      .TERM_W       (TERM_W),
      .ACC_W        (ACC_W)
    ) u_merge (
      .clk  (clk),
      .en   (en3),
      .diff (diff2_r[c]),
      .term (term[c]),
      .comp (comp[c])
    );
  end

  assign out_valid   = out_valid_r;
  assign out_comp_fx = comp[0];
  assign out_comp_fy = comp[1];
  assign out_comp_fz = comp[2];
  assign out_comp_tx = comp[3];
  assign out_comp_ty = comp[4];
  assign out_comp_tz = comp[5];

  `ASSERT_NEVER(a_stall_only_when_full, clk, rst_n,
    in_stall && !(v1_r && v2_r && out_valid_r && out_stall), "input stalled with room")
  `ASSERT_AT(a_sample_enters, clk, rst_n,
    acc_sample |=> v1_r, "accepted sample request lost")
  `ASSERT_AT(a_write_no_result, clk, rst_n,
    acc_write |=> !v1_r, "write request produced a result")

endmodule
